// ===== hdl/brr_pkg.sv =====
`timescale 1ns / 1ps

package brr_pkg;

	// Font and geometry limits
	localparam int GLYPH_MEM_DEPTH  = 32768;
	localparam int GLYPH_COUNT      = 256;
	localparam int MAX_GLYPH_HEIGHT = 32;
	localparam int MAX_GLYPH_WIDTH  = 24;
	localparam int COORD_BITS       = 10;
	localparam int RESULT_LIMIT     = 32;

	// Effective height limit: rows per glyph never exceed either bound
	localparam int H_LIMIT = (MAX_GLYPH_HEIGHT < RESULT_LIMIT) ? MAX_GLYPH_HEIGHT : RESULT_LIMIT;

	// Field widths
	localparam int ACTION_W = 2;
	localparam int ADDR_W   = 15;
	localparam int CODE_W   = 8;
	localparam int BYTE_W   = 8;
	localparam int CFG_H_W  = 6;
	localparam int RB_W     = 2;
	localparam int WIDTH_W  = 5;
	localparam int GIDX_W   = $clog2(GLYPH_COUNT);
	localparam int HEIGHT_W = $clog2(H_LIMIT + 1);

	// Glyph rows are up to three bytes, held in three byte-wide banks
	localparam int BANKS       = 3;
	localparam int MASK_W      = BYTE_W * BANKS;
	localparam int MAX_RB      = 3;
	localparam int STRIDE_W    = $clog2(H_LIMIT * MAX_RB + 1);
	localparam int LIN_W       = ADDR_W;
	localparam int BANK_DEPTH  = (GLYPH_MEM_DEPTH + BANKS - 1) / BANKS;
	localparam int BANK_AW     = $clog2(BANK_DEPTH);
	localparam int SEL_W       = 2;

	// Divide by three: floor(a * 43691 / 2^17) is exact for a < 2^15
	localparam int DIV3_SHIFT             = 17;
	localparam int DIV3_PROD_W            = LIN_W + DIV3_SHIFT;
	localparam logic [DIV3_SHIFT-1:0] DIV3_MUL = DIV3_SHIFT'(43691);

	// Queues
	localparam int CMD_DEPTH  = 8;
	localparam int CMD_PTR_W  = $clog2(CMD_DEPTH);
	localparam int CMD_CNT_W  = $clog2(CMD_DEPTH + 1);
	localparam int OUT_DEPTH  = 4;
	localparam int OUT_PTR_W  = $clog2(OUT_DEPTH);
	localparam int OUT_CNT_W  = $clog2(OUT_DEPTH + 1);

	localparam logic [CODE_W-1:0] NEWLINE_CODE = CODE_W'(10);

	// Input actions
	localparam logic [ACTION_W-1:0] ACT_LOAD_GLYPH = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_LOAD_WIDTH = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_START      = 2'd2;
	localparam logic [ACTION_W-1:0] ACT_DRAW       = 2'd3;

	// Configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_FIRST_CODE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GLYPH_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ROW_BYTES    = 2'd2;

	// Command kinds between front and back
	localparam int KIND_W = 3;
	localparam logic [KIND_W-1:0] CMD_NOP     = 3'd0;
	localparam logic [KIND_W-1:0] CMD_GLYPH   = 3'd1;
	localparam logic [KIND_W-1:0] CMD_WIDTH   = 3'd2;
	localparam logic [KIND_W-1:0] CMD_START   = 3'd3;
	localparam logic [KIND_W-1:0] CMD_NEWLINE = 3'd4;
	localparam logic [KIND_W-1:0] CMD_DRAW    = 3'd5;

	typedef struct packed {
		logic [ACTION_W-1:0]   action;
		logic [ADDR_W-1:0]     address;
		logic [BYTE_W-1:0]     load_data;
		logic [COORD_BITS-1:0] start_x;
		logic [COORD_BITS-1:0] start_y;
		logic [CODE_W-1:0]     char_code;
		logic [BYTE_W-1:0]     ink;
	} in_item_t;

	typedef struct packed {
		logic [COORD_BITS-1:0] pixel_x;
		logic [COORD_BITS-1:0] pixel_y;
		logic [MASK_W-1:0]     row_mask;
		logic [WIDTH_W-1:0]    row_width;
		logic [BYTE_W-1:0]     pen_color;
		logic                  last_row;
	} out_item_t;

	typedef struct packed {
		logic [CODE_W-1:0]   first_code;
		logic [HEIGHT_W-1:0] eff_height;
		logic [RB_W-1:0]     row_bytes;
		logic [STRIDE_W-1:0] stride;
	} cfg_t;

	typedef struct packed {
		logic [KIND_W-1:0]     kind;
		logic [BANK_AW-1:0]    bank_row;
		logic [SEL_W-1:0]      bank_sel;
		logic [GIDX_W-1:0]     windex;
		logic [BYTE_W-1:0]     data;
		logic [COORD_BITS-1:0] x;
		logic [COORD_BITS-1:0] y;
		logic [BYTE_W-1:0]     ink;
	} cmd_t;

endpackage

// ===== hdl/brr_front.sv =====
`timescale 1ns / 1ps

module brr_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  brr_pkg::in_item_t item,
	input  brr_pkg::cfg_t     cfg,
	output logic              cmd_valid,
	input  logic              cmd_pop,
	output brr_pkg::cmd_t     cmd
);
	import brr_pkg::*;

	logic                    accept;
	logic                    pop_ok;
	logic [KIND_W-1:0]       kind_c;
	logic [GIDX_W-1:0]       index_c;
	logic [BYTE_W-1:0]       data_c;

	logic                    valid_s1, valid_s2;
	logic [KIND_W-1:0]       kind_s1, kind_s2;
	logic [ADDR_W-1:0]       addr_s1;
	logic [GIDX_W-1:0]       index_s1, index_s2;
	logic [BYTE_W-1:0]       data_s1, data_s2;
	logic [COORD_BITS-1:0]   x_s1, x_s2, y_s1, y_s2;
	logic [BYTE_W-1:0]       ink_s1, ink_s2;
	logic [LIN_W-1:0]        lin_s2;

	logic [DIV3_PROD_W-1:0]  quot_prod;
	logic [LIN_W-1:0]        quot, three_q, rem;
	cmd_t                    cmd_in;

	cmd_t                    cmd_mem [CMD_DEPTH];
	logic [CMD_PTR_W:0]      wr_q, rd_q;
	logic [CMD_CNT_W-1:0]    occ_q;
	logic [CMD_PTR_W:0]      stored;

	// occ_q counts everything in the pipe and in the queue, so the queue never overflows
	assign full   = (occ_q == CMD_CNT_W'(CMD_DEPTH));
	assign accept = push && !full;
	assign pop_ok = cmd_pop && cmd_valid;

	// classify
	always_comb begin
		kind_c  = CMD_NOP;
		index_c = item.address[GIDX_W-1:0];
		data_c  = item.load_data;
		case (item.action)
			ACT_LOAD_GLYPH: begin
				// 15-bit address always lands inside the store
				kind_c = CMD_GLYPH;
			end
			ACT_LOAD_WIDTH: begin
				if (item.address < ADDR_W'(GLYPH_COUNT)) begin
					kind_c = CMD_WIDTH;
				end
				if (item.load_data > BYTE_W'(MAX_GLYPH_WIDTH)) begin
					data_c = BYTE_W'(MAX_GLYPH_WIDTH);
				end
			end
			ACT_START: begin
				kind_c = CMD_START;
			end
			ACT_DRAW: begin
				if (item.char_code == NEWLINE_CODE) begin
					kind_c = CMD_NEWLINE;
				end else begin
					kind_c = CMD_DRAW;
				end
				index_c = GIDX_W'(item.char_code - cfg.first_code);
			end
			default: begin
				kind_c = CMD_NOP;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		kind_s1  <= kind_c;
		addr_s1  <= item.address;
		index_s1 <= index_c;
		data_s1  <= data_c;
		x_s1     <= item.start_x;
		y_s1     <= item.start_y;
		ink_s1   <= item.ink;

		kind_s2  <= kind_s1;
		index_s2 <= index_s1;
		data_s2  <= data_s1;
		x_s2     <= x_s1;
		y_s2     <= y_s1;
		ink_s2   <= ink_s1;
		// byte address of row 0 of the glyph, or the load address
		if (kind_s1 == CMD_GLYPH) begin
			lin_s2 <= addr_s1;
		end else begin
			lin_s2 <= LIN_W'(index_s1) * LIN_W'(cfg.stride);
		end
	end

	// split the byte address into bank row and bank select (address / 3, address % 3)
	assign quot_prod = DIV3_PROD_W'(lin_s2) * DIV3_PROD_W'(DIV3_MUL);
	assign quot      = LIN_W'(quot_prod >> DIV3_SHIFT);
	assign three_q   = quot + (quot << 1);
	assign rem       = lin_s2 - three_q;

	always_comb begin
		cmd_in.kind     = kind_s2;
		cmd_in.bank_row = quot[BANK_AW-1:0];
		cmd_in.bank_sel = rem[SEL_W-1:0];
		cmd_in.windex   = index_s2;
		cmd_in.data     = data_s2;
		cmd_in.x        = x_s2;
		cmd_in.y        = y_s2;
		cmd_in.ink      = ink_s2;
	end

	always_ff @(posedge clk) begin
		if (valid_s2) begin
			cmd_mem[wr_q[CMD_PTR_W-1:0]] <= cmd_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			occ_q <= '0;
		end else begin
			if (valid_s2) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop_ok) begin
				rd_q <= rd_q + 1'b1;
			end
			occ_q <= occ_q + CMD_CNT_W'(accept) - CMD_CNT_W'(pop_ok);
		end
	end

	assign stored    = wr_q - rd_q;
	assign cmd_valid = (wr_q != rd_q);
	assign cmd       = cmd_mem[rd_q[CMD_PTR_W-1:0]];

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= CMD_CNT_W'(CMD_DEPTH))
		else $error("front occupancy above queue depth");

	a_stored_in_occ: assert property (@(posedge clk) disable iff (!arst_n)
		CMD_CNT_W'(stored) <= occ_q)
		else $error("queue holds more commands than were accepted");

endmodule

// ===== hdl/brr_back.sv =====
`timescale 1ns / 1ps

module brr_back (
	input  logic               clk,
	input  logic               arst_n,
	input  brr_pkg::cfg_t      cfg,
	input  logic               cmd_valid,
	output logic               cmd_pop,
	input  brr_pkg::cmd_t      cmd,
	output logic               empty,
	input  logic               pop,
	output brr_pkg::out_item_t result
);
	import brr_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_ROWS = 2'd1;

	logic [1:0]            state_q;
	logic [COORD_BITS-1:0] cur_x_q, cur_y_q, org_x_q;
	logic [HEIGHT_W-1:0]   row_q;
	logic [BANK_AW-1:0]    base_row_q;
	logic [SEL_W-1:0]      base_sel_q;
	logic [WIDTH_W-1:0]    width_q;
	logic [BYTE_W-1:0]     ink_q;

	logic [WIDTH_W-1:0]    width_mem [GLYPH_COUNT];

	logic                  take;
	logic                  rows_done;
	logic                  issue;
	logic [SEL_W:0]        sel_sum;

	logic [BYTE_W-1:0]     rd_s1    [BANKS];
	logic [SEL_W-1:0]      kslot_s1 [BANKS];
	logic                  en_s1    [BANKS];
	logic                  valid_s1;
	logic [COORD_BITS-1:0] x_s1, y_s1;
	logic [WIDTH_W-1:0]    width_s1;
	logic [BYTE_W-1:0]     ink_s1;
	logic                  last_s1;

	logic [BYTE_W-1:0]     slot_byte [BANKS];
	logic [MASK_W-1:0]     raw_mask;
	out_item_t             row_out;

	out_item_t             out_mem [OUT_DEPTH];
	logic [OUT_PTR_W:0]    owr_q, ord_q;
	logic [OUT_PTR_W:0]    out_cnt;
	logic [OUT_CNT_W-1:0]  cred_q;
	logic                  pop_ok;

	assign take      = (state_q == ST_IDLE) && cmd_valid;
	assign cmd_pop   = take;
	assign rows_done = (row_q == cfg.eff_height);
	// cred_q covers rows in the read stage and rows waiting in the result queue
	assign issue     = (state_q == ST_ROWS) && !rows_done && (cred_q != OUT_CNT_W'(OUT_DEPTH));
	assign sel_sum   = {1'b0, base_sel_q} + {1'b0, cfg.row_bytes};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cur_x_q <= '0;
			cur_y_q <= '0;
			org_x_q <= '0;
			row_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (take) begin
						case (cmd.kind)
							CMD_START: begin
								cur_x_q <= cmd.x;
								org_x_q <= cmd.x;
								cur_y_q <= cmd.y;
							end
							CMD_NEWLINE: begin
								cur_y_q <= cur_y_q + COORD_BITS'(cfg.eff_height);
								cur_x_q <= org_x_q;
							end
							CMD_DRAW: begin
								row_q   <= '0;
								state_q <= ST_ROWS;
							end
							default: begin
							end
						endcase
					end
				end
				ST_ROWS: begin
					if (rows_done) begin
						cur_x_q <= cur_x_q + COORD_BITS'(width_q);
						state_q <= ST_IDLE;
					end else if (issue) begin
						row_q <= row_q + 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// glyph base and per-draw payload; base steps by row_bytes each row
	always_ff @(posedge clk) begin
		if (take && cmd.kind == CMD_DRAW) begin
			base_row_q <= cmd.bank_row;
			base_sel_q <= cmd.bank_sel;
			ink_q      <= cmd.ink;
		end else if (issue) begin
			if (sel_sum >= (SEL_W + 1)'(BANKS)) begin
				base_sel_q <= SEL_W'(sel_sum - (SEL_W + 1)'(BANKS));
				base_row_q <= base_row_q + 1'b1;
			end else begin
				base_sel_q <= SEL_W'(sel_sum);
			end
		end
	end

	// width table, registered read on draw
	always_ff @(posedge clk) begin
		if (take && cmd.kind == CMD_WIDTH) begin
			width_mem[cmd.windex] <= cmd.data[WIDTH_W-1:0];
		end
		if (take && cmd.kind == CMD_DRAW) begin
			width_q <= width_mem[cmd.windex];
		end
	end

	// three byte banks: consecutive bytes of a row always fall in different banks
	for (genvar b = 0; b < BANKS; b++) begin : g_bank
		logic [BYTE_W-1:0]  mem [BANK_DEPTH];
		logic [SEL_W:0]     kdiff;
		logic [SEL_W-1:0]   kslot;
		logic               ken;
		logic [BANK_AW-1:0] raddr;

		always_comb begin
			kdiff = (SEL_W + 1)'(b + BANKS) - {1'b0, base_sel_q};
			if (kdiff >= (SEL_W + 1)'(BANKS)) begin
				kslot = SEL_W'(kdiff - (SEL_W + 1)'(BANKS));
			end else begin
				kslot = SEL_W'(kdiff);
			end
			ken   = (kslot < cfg.row_bytes);
			raddr = base_row_q + BANK_AW'(SEL_W'(b) < base_sel_q);
		end

		always_ff @(posedge clk) begin
			if (take && cmd.kind == CMD_GLYPH && cmd.bank_sel == SEL_W'(b)) begin
				mem[cmd.bank_row] <= cmd.data;
			end
			if (issue) begin
				rd_s1[b] <= mem[raddr];
			end
		end

		always_ff @(posedge clk) begin
			kslot_s1[b] <= kslot;
			en_s1[b]    <= ken;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		x_s1     <= cur_x_q;
		y_s1     <= cur_y_q + COORD_BITS'(row_q);
		width_s1 <= width_q;
		ink_s1   <= ink_q;
		last_s1  <= (HEIGHT_W'(row_q + 1'b1) == cfg.eff_height);
	end

	// byte slot 0 is the leftmost; bytes past row_bytes stay zero
	always_comb begin
		for (int s = 0; s < BANKS; s++) begin
			slot_byte[s] = '0;
			for (int b = 0; b < BANKS; b++) begin
				if (en_s1[b] && kslot_s1[b] == SEL_W'(s)) begin
					slot_byte[s] = slot_byte[s] | rd_s1[b];
				end
			end
		end
	end

	assign raw_mask = {slot_byte[0], slot_byte[1], slot_byte[2]};

	always_comb begin
		row_out.pixel_x   = x_s1;
		row_out.pixel_y   = y_s1;
		row_out.row_mask  = raw_mask & ~({MASK_W{1'b1}} >> width_s1);
		row_out.row_width = width_s1;
		row_out.pen_color = ink_s1;
		row_out.last_row  = last_s1;
	end

	// result queue
	always_ff @(posedge clk) begin
		if (valid_s1) begin
			out_mem[owr_q[OUT_PTR_W-1:0]] <= row_out;
		end
	end

	assign empty   = (owr_q == ord_q);
	assign pop_ok  = pop && !empty;
	assign result  = out_mem[ord_q[OUT_PTR_W-1:0]];
	assign out_cnt = owr_q - ord_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owr_q  <= '0;
			ord_q  <= '0;
			cred_q <= '0;
		end else begin
			if (valid_s1) begin
				owr_q <= owr_q + 1'b1;
			end
			if (pop_ok) begin
				ord_q <= ord_q + 1'b1;
			end
			cred_q <= cred_q + OUT_CNT_W'(issue) - OUT_CNT_W'(pop_ok);
		end
	end

	a_cred_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cred_q <= OUT_CNT_W'(OUT_DEPTH))
		else $error("result credits above queue depth");

	a_queue_in_cred: assert property (@(posedge clk) disable iff (!arst_n)
		OUT_CNT_W'(out_cnt) <= cred_q)
		else $error("result queue holds rows that were never issued");

	a_row_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROWS) |-> (row_q <= cfg.eff_height))
		else $error("row counter ran past glyph height");

endmodule

// ===== hdl/bitmap_text_row_renderer.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Handshake                  Payload
// item      in         push / full                in_item_t (action, address, load data, ...)
// result    out        pop / empty                out_item_t (one glyph row per transaction)
// config    in         cfg_valid / cfg_ready      cfg_index, cfg_data
//
// Loads, start line and newline are taken when the back end idles. The row
// sequencer reads a drawn character from three byte-wide glyph banks, one glyph
// row per cycle while the result queue has room. The front stages are s1 and s2.
// Reset (arst_n low) clears cursor, origin, queues and config to its defaults;
// glyph and width stores are not cleared. A stall on result only halts the row
// sequencer; the 8-deep command queue keeps taking items until it fills.

module bitmap_text_row_renderer (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	output logic                            full,
	input  brr_pkg::in_item_t               item,
	output logic                            empty,
	input  logic                            pop,
	output brr_pkg::out_item_t              result,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [brr_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [brr_pkg::BYTE_W-1:0]      cfg_data
);
	import brr_pkg::*;

	logic [CODE_W-1:0]   first_code_q;
	logic [CFG_H_W-1:0]  glyph_height_q;
	logic [RB_W-1:0]     row_bytes_q;
	logic [HEIGHT_W-1:0] eff_height;
	logic [STRIDE_W-1:0] stride_q;
	cfg_t                cfg;

	cmd_t                cmd;
	logic                cmd_valid;
	logic                cmd_pop;

	// config writes are always taken
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_code_q   <= CODE_W'(32);
			glyph_height_q <= CFG_H_W'(18);
			row_bytes_q    <= RB_W'(3);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_FIRST_CODE:   first_code_q   <= cfg_data;
				CFG_GLYPH_HEIGHT: glyph_height_q <= cfg_data[CFG_H_W-1:0];
				CFG_ROW_BYTES:    row_bytes_q    <= cfg_data[RB_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// height clamp applies to rows, glyph stride and newline step alike
	assign eff_height = (glyph_height_q > CFG_H_W'(H_LIMIT)) ?
		HEIGHT_W'(H_LIMIT) : HEIGHT_W'(glyph_height_q);

	// bytes per glyph; used by the front on the item held in its s1 register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stride_q <= STRIDE_W'(18 * 3);
		end else begin
			stride_q <= STRIDE_W'(eff_height) * STRIDE_W'(row_bytes_q);
		end
	end

	always_comb begin
		cfg.first_code = first_code_q;
		cfg.eff_height = eff_height;
		cfg.row_bytes  = row_bytes_q;
		cfg.stride     = stride_q;
	end

	// front: takes items, classifies, forms glyph bank addresses
	brr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.item      (item),
		.cfg       (cfg),
		.cmd_valid (cmd_valid),
		.cmd_pop   (cmd_pop),
		.cmd       (cmd)
	);

	// back: stores, cursor and the glyph row sequencer
	brr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.cmd_valid (cmd_valid),
		.cmd_pop   (cmd_pop),
		.cmd       (cmd),
		.empty     (empty),
		.pop       (pop),
		.result    (result)
	);

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

// Text row renderer testbench.
// A behavioral predictor keeps its own glyph store, width table, cursor and
// font registers. Every accepted item is run through it at the accepting
// edge, and the glyph rows it produces are queued. A checker pops each row
// that the block hands out and compares it field by field with the oldest
// queued row.
module testbench;
	import brr_pkg::*;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  push;
	logic                  full;
	in_item_t              item;
	logic                  empty;
	logic                  pop;
	out_item_t             result;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [BYTE_W-1:0]     cfg_data;

	bitmap_text_row_renderer uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.item      (item),
		.empty     (empty),
		.pop       (pop),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// 4 ns period
	always #2 clk = ~clk;

	// ---------------------------------------------------------------
	// Predictor state: a private copy of everything the block holds.
	// Draws are only issued for glyphs whose bytes and width were loaded.
	// ---------------------------------------------------------------
	logic [BYTE_W-1:0]     glyph_mem [GLYPH_MEM_DEPTH];
	logic [WIDTH_W-1:0]    width_mem [GLYPH_COUNT];
	logic [COORD_BITS-1:0] pen_x = '0;
	logic [COORD_BITS-1:0] pen_y = '0;
	logic [COORD_BITS-1:0] line_x = '0;
	logic [CODE_W-1:0]     font_first = CODE_W'(32);
	logic [CFG_H_W-1:0]    font_height = CFG_H_W'(18);
	logic [RB_W-1:0]       font_rb = RB_W'(3);

	out_item_t expected_rows[$];

	int  mismatches = 0;
	int  rows_checked = 0;
	int  items_sent = 0;
	int  fonts_used = 0;
	// when set, neither side idles: gives one long back-to-back stretch
	bit  steady = 1'b0;

	task automatic note_mismatch(input string msg);
		mismatches++;
		$display("[%0t] mismatch: %s", $time, msg);
	endtask

	function automatic bit idle_now();
		return !steady && ($urandom_range(0, 99) < 17);
	endfunction

	// Rows per glyph: the register, clipped to the hardware limit. Also the
	// glyph stride in rows and the newline advance.
	function automatic int rows_per_glyph();
		return (int'(font_height) > H_LIMIT) ? H_LIMIT : int'(font_height);
	endfunction

	// Apply one accepted item to the predictor and queue the rows it draws.
	task automatic render_rows(input in_item_t it);
		int          h;
		int          g;
		int          w;
		int          base;
		int unsigned bits;
		int unsigned keep;
		logic [CODE_W-1:0] gi;
		out_item_t   row;
		h = rows_per_glyph();
		case (it.action)
		ACT_LOAD_GLYPH: begin
			glyph_mem[it.address] = it.load_data;
		end
		ACT_LOAD_WIDTH: begin
			// addresses past the table are dropped; wide values clip at 24
			if (it.address < GLYPH_COUNT) begin
				width_mem[it.address[GIDX_W-1:0]] = (it.load_data > MAX_GLYPH_WIDTH) ?
					WIDTH_W'(MAX_GLYPH_WIDTH) : it.load_data[WIDTH_W-1:0];
			end
		end
		ACT_START: begin
			pen_x  = it.start_x;
			line_x = it.start_x;
			pen_y  = it.start_y;
		end
		ACT_DRAW: begin
			if (it.char_code == NEWLINE_CODE) begin
				// newline wins over any glyph mapping, no rows
				pen_y = pen_y + COORD_BITS'(h);
				pen_x = line_x;
			end else begin
				gi = it.char_code - font_first;
				g  = int'(gi);
				w  = int'(width_mem[gi]);
				// clear the pixels right of the glyph width
				keep = (w >= MAX_GLYPH_WIDTH) ? 32'hFF_FFFF :
					32'hFF_FFFF & ~((32'd1 << (MASK_W - w)) - 32'd1);
				for (int r = 0; r < h; r++) begin
					base = (g * h + r) * int'(font_rb);
					bits = 0;
					// bytes past row_bytes read as zero, not as the next row
					for (int k = 0; k < BANKS; k++)
						if (k < int'(font_rb))
							bits |= int'(glyph_mem[ADDR_W'((base + k) % GLYPH_MEM_DEPTH)])
								<< (16 - 8 * k);
					row.pixel_x   = pen_x;
					row.pixel_y   = pen_y + COORD_BITS'(r);
					row.row_mask  = MASK_W'(bits & keep);
					row.row_width = WIDTH_W'(w);
					row.pen_color = it.ink;
					row.last_row  = (r + 1 == h);
					expected_rows.push_back(row);
				end
				// height 0 draws nothing but still moves the cursor
				pen_x = pen_x + COORD_BITS'(w);
			end
		end
		default: ;
		endcase
	endtask

	// ---------------------------------------------------------------
	// Item side. Every task starts and ends at a falling edge. push is
	// left high between back-to-back items, so it gets one assignment
	// per step at most.
	// ---------------------------------------------------------------
	task automatic send_item(input in_item_t it);
		while (idle_now()) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push <= 1'b1;
		item <= it;
		@(posedge clk);
		while (full)
			@(posedge clk);
		render_rows(it);
		// out-of-range width loads are ignored by the block: not counted
		if (!(it.action == ACT_LOAD_WIDTH && it.address >= GLYPH_COUNT))
			items_sent++;
		@(negedge clk);
	endtask

	// Stop sending, wait for every queued row, then a quiet tail that
	// covers items still in flight that draw nothing.
	task automatic drain(input int tail);
		push <= 1'b0;
		@(negedge clk);
		while (expected_rows.size() != 0)
			@(negedge clk);
		repeat (tail) @(negedge clk);
	endtask

	// All fields random; each helper then fixes the ones that matter, so
	// the ignored fields toggle freely.
	function automatic in_item_t noise_item();
		logic [63:0] raw;
		raw = {$urandom(), $urandom()};
		return raw[$bits(in_item_t)-1:0];
	endfunction

	task automatic load_byte(input int addr, input logic [BYTE_W-1:0] val);
		in_item_t it;
		it           = noise_item();
		it.action    = ACT_LOAD_GLYPH;
		it.address   = ADDR_W'(addr);
		it.load_data = val;
		send_item(it);
	endtask

	task automatic load_width(input int idx, input logic [BYTE_W-1:0] val);
		in_item_t it;
		it           = noise_item();
		it.action    = ACT_LOAD_WIDTH;
		it.address   = ADDR_W'(idx);
		it.load_data = val;
		send_item(it);
	endtask

	task automatic start_line(input int x, input int y);
		in_item_t it;
		it         = noise_item();
		it.action  = ACT_START;
		it.start_x = COORD_BITS'(x);
		it.start_y = COORD_BITS'(y);
		send_item(it);
	endtask

	task automatic draw(input logic [CODE_W-1:0] code, input logic [BYTE_W-1:0] color);
		in_item_t it;
		it           = noise_item();
		it.action    = ACT_DRAW;
		it.char_code = code;
		it.ink       = color;
		send_item(it);
	endtask

	// Full width entry plus every byte of glyph g under the current font.
	task automatic load_glyph(input int g);
		int h;
		h = rows_per_glyph();
		load_width(g, BYTE_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) :
			$urandom_range(1, MAX_GLYPH_WIDTH)));
		for (int r = 0; r < h; r++)
			for (int k = 0; k < int'(font_rb); k++)
				load_byte(((g * h + r) * int'(font_rb) + k) % GLYPH_MEM_DEPTH,
					BYTE_W'($urandom_range(0, 255)));
	endtask

	// ---------------------------------------------------------------
	// Config side: registers only change with the pipeline empty.
	// ---------------------------------------------------------------
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
		CFG_FIRST_CODE:   font_first  = val;
		CFG_GLYPH_HEIGHT: font_height = val[CFG_H_W-1:0];
		CFG_ROW_BYTES:    font_rb     = val[RB_W-1:0];
		default: ;
		endcase
		@(negedge clk);
	endtask

	task automatic set_font(input int first, input int height, input int rb);
		drain(64);
		write_reg(CFG_FIRST_CODE, BYTE_W'(first));
		write_reg(CFG_GLYPH_HEIGHT, BYTE_W'(height));
		write_reg(CFG_ROW_BYTES, BYTE_W'(rb));
		cfg_valid <= 1'b0;
		fonts_used++;
	endtask

	// ---------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------

	// Newline straight out of reset: default height 18 from a zero cursor.
	// The rows of the next test show where it landed.
	task automatic test_after_reset();
		draw(NEWLINE_CODE, 8'h00);
	endtask

	// first_code 0xFF, so code 0x00 maps to glyph 1 and code 10 would map
	// to glyph 11 were it not a newline.
	task automatic test_glyph_edges();
		set_font(8'hFF, 2, 3);
		load_width(1, 8'hFF);          // saturates to 24
		load_byte(6, 8'hFF);
		load_byte(7, 8'h80);
		load_byte(8, 8'h01);
		load_byte(9, 8'hA5);
		load_byte(10, 8'h5A);
		load_byte(11, 8'h3C);
		draw(8'h00, 8'hFF);
		load_width(300, 8'h07);        // past the table: dropped
		load_width(1, 8'h00);          // zero width: empty rows, no advance
		draw(8'h00, 8'h00);
		load_width(1, 8'h05);          // mask clipped to five pixels
		start_line(1023, 1023);        // rows and columns wrap from here
		draw(8'h00, 8'h81);
		draw(8'h00, 8'h7E);
		draw(NEWLINE_CODE, 8'h55);
		draw(8'h00, 8'hAA);
	endtask

	// Row layouts: one byte per row, no bytes at all, zero height, and
	// heights at and over the limit.
	task automatic test_row_formats();
		set_font(0, 2, 1);
		load_width(1, 8'd24);
		load_byte(2, 8'hC3);
		load_byte(3, 8'h18);
		draw(8'h01, 8'h0F);
		set_font(0, 0, 2);
		draw(8'h01, 8'hF0);            // no rows, cursor still moves
		draw(NEWLINE_CODE, 8'h00);     // advance of zero
		set_font(8'h80, 63, 0);
		draw(8'h81, 8'h3C);            // clipped to 32 rows, empty masks
		draw(NEWLINE_CODE, 8'h00);
		set_font(8'h80, 32, 0);
		draw(8'h81, 8'hC3);
	endtask

	// Random text under one font: glyphs are loaded as full sequences,
	// then mostly drawn, with line starts, newlines and stray loads mixed
	// in. The sender pauses once mid-way until the result side is empty.
	task automatic test_random_text(input int first, input int height, input int rb,
		input int preload, input int count);
		int loaded[$];
		int stop_at;
		int g;
		int dice;
		bit paused;
		set_font(first, height, rb);
		repeat (preload) begin
			g = $urandom_range(0, GLYPH_COUNT - 1);
			load_glyph(g);
			loaded.push_back(g);
		end
		stop_at = items_sent + count;
		paused  = 1'b0;
		while (items_sent < stop_at) begin
			if (!paused && items_sent >= stop_at - count / 2) begin
				drain(0);
				paused = 1'b1;
			end
			dice = $urandom_range(0, 99);
			if (dice < 6) begin
				g = $urandom_range(0, GLYPH_COUNT - 1);
				load_glyph(g);
				loaded.push_back(g);
			end else if (dice < 14) begin
				case ($urandom_range(0, 2))
				0: load_byte($urandom_range(0, GLYPH_MEM_DEPTH - 1),
					BYTE_W'($urandom_range(0, 255)));
				1: load_width($urandom_range(GLYPH_COUNT, 32767),
					BYTE_W'($urandom_range(0, 255)));
				default: load_width($urandom_range(0, GLYPH_COUNT - 1),
					BYTE_W'($urandom_range(0, 255)));
				endcase
			end else if (dice < 22) begin
				start_line($urandom_range(0, 1023), $urandom_range(0, 1023));
			end else if (dice < 30) begin
				draw(NEWLINE_CODE, BYTE_W'($urandom_range(0, 255)));
			end else begin
				g = loaded[$urandom_range(0, loaded.size() - 1)];
				draw(CODE_W'(g + int'(font_first)), BYTE_W'($urandom_range(0, 255)));
			end
		end
	endtask

	// ---------------------------------------------------------------
	// Result side: random pop, one check per popped row
	// ---------------------------------------------------------------
	always @(negedge clk)
		pop <= !idle_now();

	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && pop && !empty) begin
			if (expected_rows.size() == 0) begin
				note_mismatch($sformatf("row at (%0d,%0d) with nothing expected",
					result.pixel_x, result.pixel_y));
			end else begin
				want = expected_rows.pop_front();
				if (result.pixel_x !== want.pixel_x)
					note_mismatch($sformatf("row %0d pixel_x %0d, want %0d",
						rows_checked, result.pixel_x, want.pixel_x));
				if (result.pixel_y !== want.pixel_y)
					note_mismatch($sformatf("row %0d pixel_y %0d, want %0d",
						rows_checked, result.pixel_y, want.pixel_y));
				if (result.row_mask !== want.row_mask)
					note_mismatch($sformatf("row %0d row_mask %06h, want %06h",
						rows_checked, result.row_mask, want.row_mask));
				if (result.row_width !== want.row_width)
					note_mismatch($sformatf("row %0d row_width %0d, want %0d",
						rows_checked, result.row_width, want.row_width));
				if (result.pen_color !== want.pen_color)
					note_mismatch($sformatf("row %0d pen_color %02h, want %02h",
						rows_checked, result.pen_color, want.pen_color));
				if (result.last_row !== want.last_row)
					note_mismatch($sformatf("row %0d last_row %0b, want %0b",
						rows_checked, result.last_row, want.last_row));
				rows_checked++;
			end
		end
	end

	// ---------------------------------------------------------------
	// Sequence
	// ---------------------------------------------------------------
	initial begin
		arst_n    = 1'b0;
		push      = 1'b0;
		item      = '0;
		pop       = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_after_reset();
		test_glyph_edges();
		test_row_formats();
		test_random_text($urandom_range(0, 255), $urandom_range(1, 4), 3, 2, 10);
		steady = 1'b1;
		test_random_text($urandom_range(0, 255), $urandom_range(2, 4), 2, 2, 10);
		steady = 1'b0;
		// largest glyph height, kept short
		test_random_text($urandom_range(0, 255), 32, 1, 1, 3);

		drain(64);
		$display("%0d glyph rows checked from %0d items across %0d font settings",
			rows_checked, items_sent, fonts_used);
		$display("loads, width clipping, line starts, newlines, wrap, 0-3 bytes per row");
		if (mismatches == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("TEST FAILED");
		end
		$finish;
	end

	// Watchdog, far beyond the slowest legal run
	initial begin
		#2_000_000;
		$display("timeout with %0d rows still expected", expected_rows.size());
		$display("TEST FAILED");
		$finish;
	end

endmodule
